### src/u16u8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_ODD_LEN   = 3'd1;
   localparam logic [2:0] ERR_HIGH_END  = 3'd2;
   localparam logic [2:0] ERR_HIGH_NLOW = 3'd3;
   localparam logic [2:0] ERR_LONE_LOW  = 3'd4;

   localparam logic [1:0] BOM_START = 2'd0;
   localparam logic [1:0] BOM_CHECK = 2'd1;
   localparam logic [1:0] BOM_PAST  = 2'd2;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;

   localparam logic [7:0] BOM_FF = 8'hFF;
   localparam logic [7:0] BOM_FE = 8'hFE;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       data_valid;
      logic       last_of_run;
      logic       stream_done;
      logic [2:0] status_code;
   } rsp_item_type;

   // one decoded job: a code point to serialize or a status result
   typedef struct packed {
      logic        is_data;
      logic [20:0] code_point;
      logic [2:0]  status_code;
      logic        eos;
   } job_type;

endpackage
`default_nettype wire

### src/u16u8_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts stream bytes, pairs them into code units, joins surrogates and
// classifies errors. Produces one job per byte that yields any result.
// ----------------------------------------------------------------------------
module u16u8_front
   import u16u8_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         lsb_first,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_data,
   input  wire logic         queue_full,
   output logic              push,
   output job_type           push_job
);

   logic [1:0] bom_phase_ff, bom_phase_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       byte_held_ff, byte_held_in;
   logic [9:0] high_payload_ff, high_payload_in;
   logic       high_pending_ff, high_pending_in;
   logic       error_latched_ff, error_latched_in;

   logic        accept;
   logic        end_mark;
   logic [7:0]  b;
   logic        have_unit;
   logic [15:0] unit;
   logic        is_high;
   logic        is_low;
   logic        emit;
   logic [20:0] cp;
   logic [2:0]  code;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign b         = req_data.in_byte;
   assign end_mark  = req_data.end_of_stream;

   always_comb begin
      bom_phase_in     = bom_phase_ff;
      held_byte_in     = held_byte_ff;
      byte_held_in     = byte_held_ff;
      high_payload_in  = high_payload_ff;
      high_pending_in  = high_pending_ff;
      error_latched_in = error_latched_ff;
      have_unit        = 1'b0;
      unit             = 16'd0;
      is_high          = 1'b0;
      is_low           = 1'b0;
      emit             = 1'b0;
      cp               = 21'd0;
      code             = ERR_NONE;
      push             = 1'b0;
      push_job         = '0;

      if (accept) begin
         if (error_latched_ff) begin
            if (end_mark) begin
               push                 = 1'b1;
               push_job.eos         = 1'b1;
               push_job.status_code = ERR_NONE;
            end
         end else begin
            if (bom_phase_ff == BOM_START) begin
               held_byte_in = b;
               byte_held_in = 1'b1;
               bom_phase_in = BOM_CHECK;
               if (end_mark) begin
                  code = ERR_ODD_LEN;
               end
            end else if (bom_phase_ff == BOM_CHECK) begin
               bom_phase_in = BOM_PAST;
               byte_held_in = 1'b0;
               if (!((held_byte_ff == BOM_FF && b == BOM_FE) ||
                     (held_byte_ff == BOM_FE && b == BOM_FF))) begin
                  have_unit = 1'b1;
               end
            end else if (!byte_held_ff) begin
               held_byte_in = b;
               byte_held_in = 1'b1;
               if (end_mark) begin
                  code = ERR_ODD_LEN;
               end
            end else begin
               byte_held_in = 1'b0;
               have_unit    = 1'b1;
            end

            unit    = lsb_first ? {b, held_byte_ff} : {held_byte_ff, b};
            is_high = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
            is_low  = (unit >= LOW_FIRST) && (unit <= LOW_LAST);

            if (have_unit) begin
               if (high_pending_ff) begin
                  high_pending_in = 1'b0;
                  high_payload_in = 10'd0;
                  if (is_low) begin
                     emit = 1'b1;
                     cp   = SUPP_BASE + {1'b0, high_payload_ff, unit[9:0]};
                  end else begin
                     code = ERR_HIGH_NLOW;
                  end
               end else if (is_high) begin
                  if (end_mark) begin
                     code = ERR_HIGH_END;
                  end else begin
                     high_pending_in = 1'b1;
                     high_payload_in = unit[9:0];
                  end
               end else if (is_low) begin
                  code = ERR_LONE_LOW;
               end else begin
                  emit = 1'b1;
                  cp   = {5'd0, unit};
               end
            end

            if (emit || code != ERR_NONE || end_mark) begin
               push                 = 1'b1;
               push_job.is_data     = emit;
               push_job.code_point  = cp;
               push_job.status_code = code;
               push_job.eos         = end_mark;
            end
            if (code != ERR_NONE) begin
               error_latched_in = 1'b1;
            end
         end

         if (end_mark) begin
            bom_phase_in     = BOM_START;
            held_byte_in     = 8'd0;
            byte_held_in     = 1'b0;
            high_payload_in  = 10'd0;
            high_pending_in  = 1'b0;
            error_latched_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bom_phase_ff     <= BOM_START;
         held_byte_ff     <= 8'd0;
         byte_held_ff     <= 1'b0;
         high_payload_ff  <= 10'd0;
         high_pending_ff  <= 1'b0;
         error_latched_ff <= 1'b0;
      end else begin
         bom_phase_ff     <= bom_phase_in;
         held_byte_ff     <= held_byte_in;
         byte_held_ff     <= byte_held_in;
         high_payload_ff  <= high_payload_in;
         high_pending_ff  <= high_pending_in;
         error_latched_ff <= error_latched_in;
      end
   end

endmodule
`default_nettype wire

### src/u16u8_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_queue
// Small job FIFO between the decode front and the byte serializer.
// ----------------------------------------------------------------------------
module u16u8_queue
   import u16u8_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   output logic         head_valid,
   output job_type      head_job,
   input  wire logic    pop
);

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

### src/u16u8_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes queued jobs into UTF-8 bytes, one result per cycle while not
// stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module u16u8_back
   import u16u8_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire job_type head_job,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_item_type rsp_data
);

   logic [1:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;
   logic         load;
   logic [1:0]   last_idx;
   logic [20:0]  cp;
   logic [7:0]   byte_sel;
   logic         is_last;

   assign cp = head_job.code_point;

   always_comb begin
      if (cp <= 21'h7F) begin
         last_idx = 2'd0;
      end else if (cp <= 21'h7FF) begin
         last_idx = 2'd1;
      end else if (cp <= 21'hFFFF) begin
         last_idx = 2'd2;
      end else begin
         last_idx = 2'd3;
      end
   end

   always_comb begin
      byte_sel = 8'h00;
      case (last_idx)
         2'd0: byte_sel = {1'b0, cp[6:0]};
         2'd1: begin
            case (idx_ff)
               2'd0:    byte_sel = {3'b110, cp[10:6]};
               default: byte_sel = {2'b10, cp[5:0]};
            endcase
         end
         2'd2: begin
            case (idx_ff)
               2'd0:    byte_sel = {4'b1110, cp[15:12]};
               2'd1:    byte_sel = {2'b10, cp[11:6]};
               default: byte_sel = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx_ff)
               2'd0:    byte_sel = {5'b11110, cp[20:18]};
               2'd1:    byte_sel = {2'b10, cp[17:12]};
               2'd2:    byte_sel = {2'b10, cp[11:6]};
               default: byte_sel = {2'b10, cp[5:0]};
            endcase
         end
      endcase
   end

   assign load    = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign is_last = !head_job.is_data || (idx_ff == last_idx);
   assign pop     = load && is_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         idx_in                  = is_last ? 2'd0 : idx_ff + 2'd1;
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_byte    = head_job.is_data ? byte_sel : 8'h00;
         rsp_data_in.data_valid  = head_job.is_data;
         rsp_data_in.last_of_run = is_last;
         rsp_data_in.stream_done = is_last && head_job.eos;
         rsp_data_in.status_code = head_job.is_data ? ERR_NONE : head_job.status_code;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### src/utf16_to_utf8_transcoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit
// UTF-16 byte stream in, UTF-8 bytes out.
//
// req channel: one UTF-16 byte per item with an end-of-stream mark; taken
// when req_valid is high and req_stall low. rsp channel: one UTF-8 byte or a
// status item per result; taken when rsp_valid is high and rsp_stall low.
// csr channel: one write sets the byte order (1 = low byte first); csr_ready
// is always high. Write it only while the block is idle.
// A decode front pushes jobs into a four-entry queue; a serializer drains it
// one result per cycle while not stalled. An accepted item's first result
// passes the queue entry, then the output register. Input is taken every
// cycle while the queue has room; a code point yields 1 to 4 output bytes.
// Reset clears the stream state, empties the queue and selects low byte first.
// While rsp_stall is high a valid output holds; the queue fills and then
// req_stall rises.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit
   import u16u8_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_data
);

   logic    lsb_first_ff;
   logic    queue_full;
   logic    push;
   job_type push_job;
   logic    head_valid;
   job_type head_job;
   logic    pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lsb_first_ff <= 1'b1;
      end else if (csr_valid) begin
         lsb_first_ff <= csr_data;
      end
   end

   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .lsb_first  (lsb_first_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   u16u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
